// ===== design/sid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed integer divider package
// Shared width constants, request and result types, sequencer states and the
// control bundle passed from the sequencer to the datapath.
// ----------------------------------------------------------------------------
package sid_pkg;

  // Operand and quotient width, and the width of the bit counter.
  localparam int DataWidth = 32;
  localparam int CntWidth  = $clog2(DataWidth);

  // One division request.
  typedef struct packed {
    logic signed [DataWidth-1:0] numerator;
    logic signed [DataWidth-1:0] denominator;
  } sid_req_t;

  // One division result.
  typedef struct packed {
    logic signed [DataWidth-1:0] quotient;
    logic                        divide_by_zero;
    logic                        overflowed;
  } sid_res_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    StIdle,
    StSetup,
    StIter,
    StFix
  } sid_state_e;

  // Control strobes from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic setup;
    logic iter;
    logic fix;
  } sid_ctrl_t;

endpackage

// ===== design/sid_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed integer divider sequencer
// Steps each request through operand setup, one iteration per quotient bit
// and the final sign fix-up, and drives the datapath strobes.
// ----------------------------------------------------------------------------
module sid_ctrl
  import sid_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  output sid_ctrl_t ctrl_o
);

  sid_state_e          state_q, state_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;

  // State and bit counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and counter.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      StIdle: begin
        if (start) begin
          state_d = StSetup;
        end
      end
      StSetup: begin
        state_d = StIter;
        cnt_d   = CntWidth'(DataWidth - 1);
      end
      StIter: begin
        if (cnt_q == '0) begin
          state_d = StFix;
        end else begin
          cnt_d = cnt_q - CntWidth'(1);
        end
      end
      StFix: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Outputs decoded from the current state.
  always_comb begin
    busy         = 1'b1;
    ctrl_o.load  = 1'b0;
    ctrl_o.setup = 1'b0;
    ctrl_o.iter  = 1'b0;
    ctrl_o.fix   = 1'b0;
    case (state_q)
      StIdle: begin
        busy        = 1'b0;
        ctrl_o.load = start;
      end
      StSetup: begin
        ctrl_o.setup = 1'b1;
      end
      StIter: begin
        ctrl_o.iter = 1'b1;
      end
      StFix: begin
        ctrl_o.fix = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== design/sid_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed integer divider datapath
// Holds the operands, turns them into magnitudes, shifts the dividend through
// a restoring subtract stage one bit per cycle and applies the sign.
// ----------------------------------------------------------------------------
module sid_datapath
  import sid_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sid_ctrl_t ctrl_i,
  input  sid_req_t  req_i,
  output logic      done_o,
  output sid_res_t  res_o
);

  localparam logic [DataWidth-1:0] MinVal = {1'b1, {(DataWidth-1){1'b0}}};
  localparam logic [DataWidth-1:0] MaxVal = {1'b0, {(DataWidth-1){1'b1}}};

  logic [DataWidth-1:0] num_q, den_q;
  logic [DataWidth-1:0] den_mag_q;
  logic [DataWidth-1:0] rem_q, rem_d;
  logic [DataWidth-1:0] quo_q, quo_d;
  logic                 neg_q, dz_q, ovf_q;
  logic                 done_q;
  sid_res_t             res_q;

  logic [DataWidth:0]   rem_shift;
  logic [DataWidth:0]   diff;
  logic                 q_bit;
  logic [DataWidth-1:0] num_mag, den_mag;
  logic [DataWidth-1:0] quo_signed;

  // Magnitudes of the captured operands.
  assign num_mag = num_q[DataWidth-1] ? (DataWidth'(0) - num_q) : num_q;
  assign den_mag = den_q[DataWidth-1] ? (DataWidth'(0) - den_q) : den_q;

  // Restoring step: bring in the next dividend bit and try the subtract.
  assign rem_shift = {rem_q, quo_q[DataWidth-1]};
  assign diff      = rem_shift - {1'b0, den_mag_q};
  assign q_bit     = ~diff[DataWidth];

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (ctrl_i.setup) begin
      rem_d = '0;
      quo_d = num_mag;
    end else if (ctrl_i.iter) begin
      rem_d = q_bit ? diff[DataWidth-1:0] : rem_shift[DataWidth-1:0];
      quo_d = {quo_q[DataWidth-2:0], q_bit};
    end
  end

  // Quotient with the sign applied.
  assign quo_signed = neg_q ? (DataWidth'(0) - quo_q) : quo_q;

  // Operand, shift and flag registers.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      num_q <= req_i.numerator;
      den_q <= req_i.denominator;
    end
    if (ctrl_i.setup) begin
      den_mag_q <= den_mag;
      neg_q     <= num_q[DataWidth-1] ^ den_q[DataWidth-1];
      dz_q      <= (den_q == '0);
      ovf_q     <= (num_q == MinVal) && (den_q == '1);
    end
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  // Result register, loaded once per request.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.fix) begin
      res_q.divide_by_zero <= dz_q;
      res_q.overflowed     <= ovf_q & ~dz_q;
      if (dz_q) begin
        res_q.quotient <= '0;
      end else if (ovf_q) begin
        res_q.quotient <= MaxVal;
      end else begin
        res_q.quotient <= quo_signed;
      end
    end
  end

  // Result strobe, high for one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl_i.fix;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== design/signed_integer_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed integer divider
// Signed division truncated toward zero with divide-by-zero and overflow flags.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low.
// Its result appears on res_o with done_o high for exactly one cycle, after
// a setup step forms the operand magnitudes, the restoring subtract stage
// retires one quotient bit per cycle, and a fix-up step applies the sign.
// The receiver cannot stall the block, so it must take the result in the
// cycle done_o is high; busy falls in that same cycle and a new request may
// be issued at once.
// A zero divisor gives quotient 0 with divide_by_zero set; the most negative
// value divided by minus one saturates to the largest positive value with
// overflowed set.
module signed_integer_divider
  import sid_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  sid_req_t req_i,
  output logic     done_o,
  output sid_res_t res_o
);

  sid_ctrl_t ctrl;

  // Sequencer.
  sid_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .ctrl_o (ctrl)
  );

  // Shift-and-subtract datapath.
  sid_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

endmodule
